// ----- rtl/core/cdsso_pkg.sv -----
// Package for the CD sector sync offset finder.
// Shared types, control/status structs and fixed constants.
// No dependencies.
package cdsso_pkg;

  // Register and index widths.
  localparam int unsigned IdxW = 13;

  // Reset value of the search window register.
  localparam logic [IdxW-1:0] WindowReset = 13'd4704;

  // Sync pattern: one edge byte, ten fill bytes, one edge byte.
  localparam int unsigned  SyncLen  = 12;
  localparam logic [7:0]   SyncEdge = 8'h00;
  localparam logic [7:0]   SyncFill = 8'hFF;

  // Header scrambler seed.
  localparam logic [14:0]  ScrSeed = 15'h0001;

  // Time code to sector conversion.
  localparam logic [13:0]  SecPerMin   = 14'd60;
  localparam logic [20:0]  FramesPerSec = 21'd75;
  localparam logic [20:0]  LeadIn      = 21'd150;
  localparam logic [12:0]  SectorBytes = 13'd2352;

  // Latency of the offset arithmetic pipeline, in cycles.
  localparam logic [2:0]   CalcCycles = 3'd5;

  // Result status codes.
  typedef enum logic [1:0] {
    StFound  = 2'd0,
    StNoSync = 2'd1,
    StTrunc  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;        // shift the byte into history, advance the index
    logic    hdr_start;   // capture the sync position, reseed the scrambler
    logic    hdr_push;    // descramble and store one header byte
    logic    restart;     // clear the buffer index for a new buffer
    logic    load_fail;   // load an error result
    status_e fail_code;
    logic    load_found;  // load the computed result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_ge_win;     // current index already at or past the window
    logic idx_end_win;    // current byte is the last one inside the window
    logic sync_match;     // current byte completes a sync pattern
    logic hdr_third;      // current header byte is the third one
  } dp_stat_t;

endpackage

// ----- rtl/core/cdsso_in_if.sv -----
// Input channel of the CD sector sync offset finder: one raw byte per transfer.
// Stand-alone interface, no dependencies.
interface cdsso_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/cdsso_out_if.sv -----
// Result channel of the CD sector sync offset finder: one result per buffer.
// Stand-alone interface, no dependencies.
interface cdsso_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [12:0]        sync_position;
  logic [7:0]         minute_bcd;
  logic [7:0]         second_bcd;
  logic [7:0]         frame_bcd;
  logic signed [31:0] byte_offset;
  logic signed [29:0] sample_offset;

  modport source (output valid, output status, output sync_position, output minute_bcd,
                  output second_bcd, output frame_bcd, output byte_offset,
                  output sample_offset, input ready);
  modport sink   (input valid, input status, input sync_position, input minute_bcd,
                  input second_bcd, input frame_bcd, input byte_offset,
                  input sample_offset, output ready);
endinterface

// ----- rtl/core/cdsso_datapath.sv -----
// Datapath: window register, byte history, header descrambler, offset pipeline
// and result register. Depends on cdsso_pkg; driven by cdsso_ctrl commands.
module cdsso_datapath import cdsso_pkg::*; #(
  parameter int unsigned MaxWindow = 4704
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IdxW-1:0]    cfg_wdata_i,
  input  logic [7:0]         data_byte_i,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  output status_e            status_o,
  output logic [IdxW-1:0]    sync_position_o,
  output logic [7:0]         minute_bcd_o,
  output logic [7:0]         second_bcd_o,
  output logic [7:0]         frame_bcd_o,
  output logic signed [31:0] byte_offset_o,
  output logic signed [29:0] sample_offset_o
);

  localparam logic [IdxW:0] MaxWin = (IdxW+1)'(MaxWindow);

  // Advance the scrambler by eight bit steps.
  function automatic logic [14:0] scr_adv8(input logic [14:0] s);
    logic [14:0] r;
    r = s;
    for (int j = 0; j < 8; j++) begin
      r = {r[0] ^ r[1], r[14:1]};
    end
    return r;
  endfunction

  // Binary value of a two-digit BCD byte.
  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    return 8'({4'b0, b[7:4]} * 8'd10) + {4'b0, b[3:0]};
  endfunction

  logic [IdxW-1:0]    win_q;
  logic [IdxW-1:0]    idx_q;
  logic [7:0]         recent_q [11];
  logic [IdxW-1:0]    found_q;
  logic [23:0]        header_q;
  logic [14:0]        scr_q;
  logic [1:0]         hdr_cnt_q;
  logic [7:0]         m_q, s_q, f_q;
  logic [13:0]        ms_q;
  logic signed [20:0] sector_q;
  logic signed [31:0] prod_q;
  logic signed [31:0] boff_q;
  logic [IdxW:0]      win_eff;
  logic [IdxW:0]      idx_next;
  logic               match;
  logic signed [31:0] boff_adj;
  logic signed [31:0] soff_full;

  // Effective window, limited to the synthesized maximum.
  assign win_eff  = ({1'b0, win_q} > MaxWin) ? MaxWin : {1'b0, win_q};
  assign idx_next = {1'b0, idx_q} + 1'b1;

  // Sync detection over the eleven previous bytes and the current one.
  always_comb begin
    match = (idx_q >= IdxW'(SyncLen - 1)) && (data_byte_i == SyncEdge) &&
            (recent_q[0] == SyncEdge);
    for (int k = 1; k < 11; k++) begin
      match = match && (recent_q[k] == SyncFill);
    end
  end

  assign stat_o.idx_ge_win  = ({1'b0, idx_q} >= win_eff);
  assign stat_o.idx_end_win = (idx_next >= win_eff);
  assign stat_o.sync_match  = match;
  assign stat_o.hdr_third   = (hdr_cnt_q == 2'd2);

  // Window register, buffer index and header byte count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= WindowReset;
      idx_q     <= '0;
      hdr_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (cmd_i.restart) begin
        idx_q <= '0;
      end else if (cmd_i.push && (idx_q != '1)) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.hdr_start) begin
        hdr_cnt_q <= '0;
      end else if (cmd_i.hdr_push) begin
        hdr_cnt_q <= hdr_cnt_q + 1'b1;
      end
    end
  end

  // Byte history, sync position and descrambled header.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      for (int k = 0; k < 10; k++) begin
        recent_q[k] <= recent_q[k+1];
      end
      recent_q[10] <= data_byte_i;
    end
    if (cmd_i.hdr_start) begin
      found_q  <= idx_q - IdxW'(SyncLen - 1);
      header_q <= '0;
      scr_q    <= ScrSeed;
    end else if (cmd_i.hdr_push) begin
      header_q <= {header_q[15:0], data_byte_i ^ scr_q[7:0]};
      scr_q    <= scr_adv8(scr_q);
    end
  end

  // Offset pipeline; inputs hold still while the controller waits it out.
  always_ff @(posedge clk_i) begin
    m_q      <= bcd_val(header_q[23:16]);
    s_q      <= bcd_val(header_q[15:8]);
    f_q      <= bcd_val(header_q[7:0]);
    ms_q     <= 14'(m_q) * SecPerMin + 14'(s_q);
    sector_q <= $signed(21'(ms_q) * FramesPerSec + 21'(f_q) - LeadIn);
    prod_q   <= $signed(32'(sector_q) * 32'(SectorBytes));
    boff_q   <= $signed({{(32-IdxW){1'b0}}, found_q}) - prod_q;
  end

  // Divide by four, rounding toward zero.
  assign boff_adj  = boff_q + $signed({30'b0, {2{boff_q[31]}}});
  assign soff_full = boff_adj >>> 2;

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_fail) begin
      status_o        <= cmd_i.fail_code;
      sync_position_o <= '0;
      minute_bcd_o    <= '0;
      second_bcd_o    <= '0;
      frame_bcd_o     <= '0;
      byte_offset_o   <= '0;
      sample_offset_o <= '0;
    end else if (cmd_i.load_found) begin
      status_o        <= StFound;
      sync_position_o <= found_q;
      minute_bcd_o    <= header_q[23:16];
      second_bcd_o    <= header_q[15:8];
      frame_bcd_o     <= header_q[7:0];
      byte_offset_o   <= boff_q;
      sample_offset_o <= soff_full[29:0];
    end
  end

endmodule

// ----- rtl/core/cdsso_ctrl.sv -----
// Controller: search phase state machine, arithmetic wait and result handshake.
// Depends on cdsso_pkg; commands cdsso_datapath.
module cdsso_ctrl import cdsso_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_SEARCH,
    S_HEADER,
    S_DONE,
    S_CALC,
    S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       accept;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = ((state_q == S_SEARCH) || (state_q == S_HEADER) ||
                        (state_q == S_DONE)) && slot_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_SEARCH, S_HEADER: begin
        if (accept) begin
          if (stat_i.idx_ge_win) begin
            cmd_o.load_fail = 1'b1;
            cmd_o.fail_code = (state_q == S_HEADER) ? StTrunc : StNoSync;
            state_d         = S_DONE;
          end else if (state_q == S_SEARCH) begin
            cmd_o.push = 1'b1;
            if (stat_i.sync_match) begin
              cmd_o.hdr_start = 1'b1;
              state_d         = S_HEADER;
            end
            if (in_last_i || stat_i.idx_end_win) begin
              cmd_o.load_fail = 1'b1;
              cmd_o.fail_code = stat_i.sync_match ? StTrunc : StNoSync;
              state_d         = S_DONE;
            end
          end else begin
            cmd_o.hdr_push = 1'b1;
            if (stat_i.hdr_third) begin
              state_d = S_CALC;
              cnt_d   = '0;
              last_d  = in_last_i;
            end else begin
              cmd_o.push = 1'b1;
              if (in_last_i || stat_i.idx_end_win) begin
                cmd_o.load_fail = 1'b1;
                cmd_o.fail_code = StTrunc;
                state_d         = S_DONE;
              end
            end
          end
          // A marked last byte always starts a new buffer.
          if (in_last_i) begin
            cmd_o.restart = 1'b1;
            if (state_d != S_CALC) begin
              state_d = S_SEARCH;
            end
          end
        end
      end
      S_DONE: begin
        if (accept && in_last_i) begin
          cmd_o.restart = 1'b1;
          state_d       = S_SEARCH;
        end
      end
      S_CALC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CalcCycles - 1'b1) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.load_found = 1'b1;
          state_d          = last_q ? S_SEARCH : S_DONE;
        end
      end
      default: begin
        state_d = S_SEARCH;
      end
    endcase
    if (cmd_o.load_fail || cmd_o.load_found) begin
      out_valid_d = 1'b1;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SEARCH;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A completed header always hands over to the arithmetic wait.
  a_hdr_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (state_q == S_HEADER) && stat_i.hdr_third && !stat_i.idx_ge_win)
    |=> (state_q == S_CALC))
    else $error("completed header did not start the offset computation");

  // A pending result is never dropped without a transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped without a transfer");

  // A new result is only loaded into a free or draining slot.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_fail || cmd_o.load_found) |-> slot_free)
    else $error("result loaded over an untaken result");

  // The arithmetic wait never runs past the pipeline latency.
  a_calc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> (cnt_q < CalcCycles))
    else $error("offset wait counter overran");
`endif

endmodule

// ----- rtl/core/cd_sector_sync_offset_finder_core.sv -----
// Channel   Direction  Transfer moves
// byte_i    in         one raw buffer byte and its last-byte mark
// result_o  out        status, sync position, header and offsets of one buffer
// cfg       in         search window write, taken on any cycle cfg_we_i is high
//
// Bytes are taken one per cycle while the block searches or collects the header.
// The byte that completes the header blocks input while the five-stage offset
// pipeline (BCD, minutes, sector, multiply, subtract) runs and its result loads.
// Error results load directly on the deciding byte; input stalls only while a
// result waits untaken. Reset clears the search state and the window to 4704.
// Top level of the CD sector sync offset finder; depends on cdsso_pkg, the two
// channel interfaces, cdsso_ctrl and cdsso_datapath.
module cd_sector_sync_offset_finder_core import cdsso_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 4704
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_wdata_i,
  cdsso_in_if.sink        byte_i,
  cdsso_out_if.source     result_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_e  status;

  // Control.
  cdsso_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .in_last_i   (byte_i.last_byte),
    .in_ready_o  (byte_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Data.
  cdsso_datapath #(
    .MaxWindow (MAX_WINDOW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .data_byte_i     (byte_i.data_byte),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status),
    .sync_position_o (result_o.sync_position),
    .minute_bcd_o    (result_o.minute_bcd),
    .second_bcd_o    (result_o.second_bcd),
    .frame_bcd_o     (result_o.frame_bcd),
    .byte_offset_o   (result_o.byte_offset),
    .sample_offset_o (result_o.sample_offset)
  );

  assign result_o.status = status;

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the CD sector sync offset finder core: directed and random capture buffers.
// Depends on cdsso_pkg, cdsso_in_if, cdsso_out_if and cd_sector_sync_offset_finder_core.
`timescale 1ns / 100ps

module tb_top;
  import cdsso_pkg::*;

  localparam int unsigned MaxWindow     = 4704;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBytes   = 420;
  localparam int unsigned RandomResults = 24;

  // Phases of the search as the predictor tracks them.
  typedef enum logic [1:0] {
    SeekSync   = 2'd0,
    TakeHeader = 2'd1,
    Settled    = 2'd2
  } seek_phase_e;

  typedef struct {
    status_e     status;
    logic [12:0] sync_position;
    logic [7:0]  minute_bcd;
    logic [7:0]  second_bcd;
    logic [7:0]  frame_bcd;
    logic [31:0] byte_offset;
    logic [29:0] sample_offset;
  } sector_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [IdxW-1:0] cfg_wdata;

  cdsso_in_if  byte_if ();
  cdsso_out_if result_if ();

  cd_sector_sync_offset_finder_core #(
    .MAX_WINDOW (MaxWindow)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .byte_i      (byte_if),
    .result_o    (result_if)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state of the block and the results it still owes.
  logic [IdxW-1:0] window_reg;
  logic [87:0]     history;
  logic [IdxW-1:0] byte_idx;
  seek_phase_e     seek_phase;
  logic [IdxW-1:0] sync_at;
  logic [23:0]     header_acc;
  logic [14:0]     descr_lfsr;
  sector_result_t  pending_offsets[$];

  // Test control and counters.
  logic [7:0]  stream_q[$];
  bit          send_gaps = 1'b1;
  bit          take_gaps = 1'b1;
  bit          hold_req  = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned accepted_bytes = 0;
  int unsigned results_taken  = 0;
  int unsigned idle_cycles    = 0;

  // Advances the header descrambler by one byte.
  function automatic logic [14:0] lfsr_next8(logic [14:0] s);
    for (int i = 0; i < 8; i++) s = {s[0] ^ s[1], s[14:1]};
    return s;
  endfunction

  function automatic int bcd_to_int(logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned n);
    return {4'(n / 10), 4'(n % 10)};
  endfunction

  function automatic void restart_search();
    history    = '0;
    byte_idx   = '0;
    seek_phase = SeekSync;
    sync_at    = '0;
    header_acc = '0;
    descr_lfsr = ScrSeed;
  endfunction

  // Error outcome: truncated header if a sync was seen, otherwise no sync.
  function automatic void post_error();
    sector_result_t r;
    r = '{default: '0, status: StNoSync};
    if (seek_phase == TakeHeader) r.status = StTrunc;
    seek_phase = Settled;
    pending_offsets.push_back(r);
  endfunction

  // Works out what one accepted byte does to the search and queues its result.
  function automatic void predict_sector_offset(logic [7:0] b, logic last);
    int unsigned    win;
    int unsigned    idx;
    int unsigned    got;
    bit             emitted;
    longint         sector;
    longint         boff;
    longint         soff;
    sector_result_t r;
    win     = (window_reg > MaxWindow) ? MaxWindow : window_reg;
    idx     = byte_idx;
    emitted = 1'b0;
    if (seek_phase != Settled) begin
      if (idx >= win) begin
        post_error();
        emitted = 1'b1;
      end else if (seek_phase == SeekSync) begin
        if (idx >= SyncLen - 1 && b == SyncEdge && history == {SyncEdge, {10{SyncFill}}}) begin
          sync_at    = IdxW'(idx - (SyncLen - 1));
          seek_phase = TakeHeader;
          header_acc = '0;
          descr_lfsr = ScrSeed;
        end
      end else begin
        got        = idx - sync_at - SyncLen;
        header_acc = {header_acc[15:0], b ^ descr_lfsr[7:0]};
        descr_lfsr = lfsr_next8(descr_lfsr);
        if (got >= 2) begin
          sector = (longint'(bcd_to_int(header_acc[23:16])) * longint'(SecPerMin)
                    + bcd_to_int(header_acc[15:8])) * longint'(FramesPerSec)
                   + bcd_to_int(header_acc[7:0]) - longint'(LeadIn);
          boff = longint'(sync_at) - sector * longint'(SectorBytes);
          soff = boff / 4;
          r.status        = StFound;
          r.sync_position = sync_at;
          r.minute_bcd    = header_acc[23:16];
          r.second_bcd    = header_acc[15:8];
          r.frame_bcd     = header_acc[7:0];
          r.byte_offset   = boff[31:0];
          r.sample_offset = soff[29:0];
          seek_phase      = Settled;
          pending_offsets.push_back(r);
          emitted = 1'b1;
        end
      end
      if (!emitted) begin
        history = {history[79:0], b};
        if (byte_idx != '1) byte_idx = byte_idx + 1'b1;
        if (last || idx + 1 >= win) post_error();
      end
    end
    if (last) restart_search();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Compares one result transfer against the oldest expectation.
  task automatic check_result();
    sector_result_t want;
    if (pending_offsets.size() == 0) begin
      report_mismatch("result with nothing expected, status", result_if.status, '0);
    end else begin
      want = pending_offsets.pop_front();
      if (result_if.status !== want.status)
        report_mismatch("status", result_if.status, want.status);
      if (result_if.sync_position !== want.sync_position)
        report_mismatch("sync_position", result_if.sync_position, want.sync_position);
      if (result_if.minute_bcd !== want.minute_bcd)
        report_mismatch("minute_bcd", result_if.minute_bcd, want.minute_bcd);
      if (result_if.second_bcd !== want.second_bcd)
        report_mismatch("second_bcd", result_if.second_bcd, want.second_bcd);
      if (result_if.frame_bcd !== want.frame_bcd)
        report_mismatch("frame_bcd", result_if.frame_bcd, want.frame_bcd);
      if (result_if.byte_offset !== want.byte_offset)
        report_mismatch("byte_offset", result_if.byte_offset, want.byte_offset);
      if (result_if.sample_offset !== want.sample_offset)
        report_mismatch("sample_offset", result_if.sample_offset, want.sample_offset);
    end
  endtask

  // Observes transfers on both channels and watches for a hung run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        check_result();
        results_taken++;
      end
      if (byte_if.valid && byte_if.ready) begin
        predict_sector_offset(byte_if.data_byte, byte_if.last_byte);
        accepted_bytes++;
      end
      if ((result_if.valid && result_if.ready) || (byte_if.valid && byte_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : result_taker
    int unsigned gap;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        result_if.ready <= 1'b1;
      end else begin
        gap = take_gaps ? pick_gap() : 0;
        if (gap == 0) begin
          result_if.ready <= 1'b1;
        end else begin
          result_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          result_if.ready <= 1'b1;
        end
      end
    end
  end

  // Offers one byte and returns at the edge where its transfer happens.
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= last;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  // Sends the staged bytes; end_mark flags the final one as the buffer end.
  task automatic send_stream(bit end_mark);
    logic [7:0] b;
    while (stream_q.size() != 0) begin
      b = stream_q.pop_front();
      send_byte(b, end_mark && stream_q.size() == 0);
    end
  endtask

  // Noise leans toward sync bytes so that partial patterns show up.
  function automatic void push_noise(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) stream_q.push_back(SyncEdge);
      else if (r == 1) stream_q.push_back(SyncFill);
      else stream_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void push_sync();
    stream_q.push_back(SyncEdge);
    repeat (10) stream_q.push_back(SyncFill);
    stream_q.push_back(SyncEdge);
  endfunction

  // The first n bytes of a sync pattern followed by one wrong byte.
  function automatic void push_broken_sync();
    int unsigned n;
    logic [7:0]  good;
    n = $urandom_range(1, 11);
    for (int k = 0; k < n; k++) stream_q.push_back((k == 0) ? SyncEdge : SyncFill);
    good = (n == SyncLen - 1) ? SyncEdge : SyncFill;
    stream_q.push_back(good ^ 8'($urandom_range(1, 255)));
  endfunction

  // Scrambles the first n bytes of a plain minute/second/frame header.
  function automatic void push_header(logic [23:0] plain, int unsigned n);
    logic [14:0] key;
    key = ScrSeed;
    for (int k = 0; k < n; k++) begin
      stream_q.push_back(plain[23 - 8*k -: 8] ^ key[7:0]);
      key = lfsr_next8(key);
    end
  endfunction

  // Mostly a legal time code, sometimes arbitrary header bytes.
  function automatic logic [23:0] pick_msf();
    if ($urandom_range(0, 4) == 0) return 24'($urandom);
    return {to_bcd($urandom_range(0, 99)), to_bcd($urandom_range(0, 59)),
            to_bcd($urandom_range(0, 74))};
  endfunction

  // Writes the window once the block has gone quiet.
  task automatic set_window(logic [IdxW-1:0] w);
    byte_if.valid <= 1'b0;
    // First let the monitor book the last transfer.
    @(posedge clk_i);
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= w;
    window_reg = w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Time code extremes, offset signs and the rounding of the sample offset.
  task automatic test_found_headers();
    push_sync();
    push_header({8'h00, 8'h02, 8'h00}, 3);
    send_stream(1);
    push_noise(3);
    push_sync();
    push_header(24'hFFFFFF, 3);
    push_noise(2);
    send_stream(1);
    // Bytes after the result, even a full sync, are ignored until the buffer ends.
    push_sync();
    push_header({8'h99, 8'h59, 8'h74}, 3);
    push_sync();
    send_stream(1);
    // A leading extra edge byte shifts the sync to index 1; negative odd offset.
    stream_q.push_back(SyncEdge);
    push_sync();
    push_header({8'h00, 8'h02, 8'h01}, 3);
    send_stream(1);
    push_sync();
    push_header(24'h000000, 3);
    send_stream(1);
  endtask

  // Buffers that end before the outcome is known.
  task automatic test_early_end();
    push_noise(4);
    send_stream(1);
    push_noise(1);
    send_stream(1);
    push_sync();
    send_stream(1);
    push_sync();
    push_header(pick_msf(), 1);
    send_stream(1);
  endtask

  // Window limits, window zero, oversize window and lowering it mid-buffer.
  task automatic test_window_edges();
    set_window(13'd15);
    push_sync();
    push_header(pick_msf(), 3);
    send_stream(1);
    set_window(13'd14);
    push_sync();
    push_header(pick_msf(), 2);
    send_stream(1);
    set_window(13'd11);
    push_sync();
    send_stream(1);
    set_window(13'd0);
    push_noise(2);
    send_stream(1);
    set_window(13'd8191);
    push_noise(2);
    push_sync();
    push_header(pick_msf(), 3);
    send_stream(1);
    set_window(WindowReset);
    push_noise(20);
    send_stream(0);
    set_window(13'd10);
    push_noise(2);
    send_stream(1);
    set_window(WindowReset);
    push_sync();
    push_header(pick_msf(), 1);
    send_stream(0);
    set_window(13'd12);
    push_noise(2);
    send_stream(1);
  endtask

  // The receiver holds off while buffers keep coming, so the input stalls.
  task automatic test_backpressure();
    set_window(13'd15);
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    repeat (4) begin
      push_sync();
      push_header(pick_msf(), 3);
      send_stream(1);
      push_noise(2);
      send_stream(1);
    end
    send_gaps = 1'b1;
  endtask

  function automatic void stage_random_buffer();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      push_noise($urandom_range(0, 12));
      push_sync();
      push_header(pick_msf(), 3);
      push_noise($urandom_range(0, 3));
    end else if (kind == 6) begin
      push_noise($urandom_range(1, 30));
    end else if (kind < 9) begin
      push_noise($urandom_range(0, 6));
      push_broken_sync();
      if ($urandom_range(0, 1) == 1) begin
        push_sync();
        push_header(pick_msf(), 3);
      end
    end else begin
      push_noise($urandom_range(0, 8));
      push_sync();
      push_header(pick_msf(), $urandom_range(0, 2));
    end
  endfunction

  // Random buffers over a series of windows, with and without idling.
  task automatic test_random_buffers();
    int unsigned phase_no;
    int unsigned bytes_base;
    int unsigned results_base;
    logic [IdxW-1:0] w;
    phase_no     = 0;
    bytes_base   = accepted_bytes;
    results_base = results_taken;
    while (accepted_bytes - bytes_base < RandomBytes
           || results_taken - results_base < RandomResults) begin
      case (phase_no % 6)
        0:       w = 13'd15;
        1:       w = WindowReset;
        2:       w = IdxW'($urandom_range(15, 40));
        3:       w = '1;
        4:       w = IdxW'($urandom_range(16, 60));
        default: w = IdxW'($urandom_range(0, 14));
      endcase
      set_window(w);
      send_gaps = (phase_no % 4) != 3;
      take_gaps = (phase_no % 5) != 2;
      repeat (4) begin
        stage_random_buffer();
        send_stream(1);
      end
      phase_no++;
    end
    send_gaps = 1'b1;
    take_gaps = 1'b1;
  endtask

  initial begin : run_tests
    window_reg = WindowReset;
    restart_search();
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last_byte <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_found_headers();
    test_early_end();
    test_window_edges();
    test_backpressure();
    test_random_buffers();

    // Drain what is still owed, then give the pipeline time to misbehave.
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
